// File: design/stuffed_frame_builder_top_assert.svh
// Assertion macros for the stuffed frame builder.
// Used by stuffed_frame_builder_top.sv; no other dependencies.
`ifndef STUFFED_FRAME_BUILDER_TOP_ASSERT_SVH
`define STUFFED_FRAME_BUILDER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sfb_pkg.sv
// Shared types, constants and the stuffing helper for the stuffed frame builder.
// No dependencies.
package sfb_pkg;

    localparam int DATA_W    = 8;
    localparam int NUM_SLOTS = 9;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR = 2'd1;

    localparam logic [DATA_W-1:0] FLAG_RESET = 8'h7E;
    localparam logic [DATA_W-1:0] ADDR_RESET = 8'h03;
    localparam logic [DATA_W-1:0] ESC_BYTE   = 8'h7D;
    localparam logic [DATA_W-1:0] ESC_FLAG   = 8'h5E;
    localparam logic [DATA_W-1:0] ESC_ESC    = 8'h5D;
    localparam logic [DATA_W-1:0] CTRL_SEQ1  = 8'h40;
    localparam logic [DATA_W-1:0] CTRL_SEQ0  = 8'h00;

    // burst slot positions, in output order
    localparam int SLOT_HDR_FLAG = 0;
    localparam int SLOT_HDR_ADDR = 1;
    localparam int SLOT_HDR_CTRL = 2;
    localparam int SLOT_HDR_CHK  = 3;
    localparam int SLOT_DATA0    = 4;
    localparam int SLOT_DATA1    = 5;
    localparam int SLOT_CHK0     = 6;
    localparam int SLOT_CHK1     = 7;
    localparam int SLOT_CLOSE    = 8;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
        logic              seq_bit;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] tx_byte;
        logic              run_last;
        logic              frame_end;
    } t_out_item;

    // all result bytes of one item; mask bit set = slot is emitted
    typedef struct packed {
        logic [NUM_SLOTS-1:0]             mask;
        logic [NUM_SLOTS-1:0][DATA_W-1:0] slots;
    } t_burst;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] pending;
        logic                 in_stall;
    } t_emit_stat;

    typedef struct packed {
        logic              dbl;
        logic [DATA_W-1:0] b0;
        logic [DATA_W-1:0] b1;
    } t_stuffed;

    // flag test wins when the flag equals the escape byte
    function automatic t_stuffed stuff_byte(input logic [DATA_W-1:0] b,
                                            input logic [DATA_W-1:0] flag);
        t_stuffed s;
        if (b == flag) begin
            s.dbl = 1'b1;
            s.b0  = ESC_BYTE;
            s.b1  = ESC_FLAG;
        end else if (b == ESC_BYTE) begin
            s.dbl = 1'b1;
            s.b0  = ESC_BYTE;
            s.b1  = ESC_ESC;
        end else begin
            s.dbl = 1'b0;
            s.b0  = b;
            s.b1  = b;
        end
        return s;
    endfunction

endpackage

// File: design/sfb_builder.sv
// Frame state, configuration registers and burst formation for one input item.
// Depends on sfb_pkg.
module sfb_builder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sfb_pkg::DATA_W-1:0]       i_cfg_wdata,
    input  logic                             i_accept,
    input  sfb_pkg::t_in_item                i_item,
    output sfb_pkg::t_burst                  o_burst
);

    logic [sfb_pkg::DATA_W-1:0] r_flag, n_flag;
    logic [sfb_pkg::DATA_W-1:0] r_addr, n_addr;
    logic [sfb_pkg::DATA_W-1:0] r_check, n_check;
    logic                       r_open, n_open;

    logic                       w_active;
    logic [sfb_pkg::DATA_W-1:0] w_ctrl;
    logic [sfb_pkg::DATA_W-1:0] w_chk_new;
    sfb_pkg::t_stuffed          w_sd;
    sfb_pkg::t_stuffed          w_sc;

    always_comb begin
        // a byte outside an open frame is dropped unless it opens one
        w_active  = i_item.first_byte | r_open;
        w_ctrl    = i_item.seq_bit ? sfb_pkg::CTRL_SEQ1 : sfb_pkg::CTRL_SEQ0;
        w_chk_new = (i_item.first_byte ? '0 : r_check) ^ i_item.data_byte;
        w_sd      = sfb_pkg::stuff_byte(i_item.data_byte, r_flag);
        w_sc      = sfb_pkg::stuff_byte(w_chk_new, r_flag);

        o_burst.slots = '0;
        o_burst.slots[sfb_pkg::SLOT_HDR_FLAG] = r_flag;
        o_burst.slots[sfb_pkg::SLOT_HDR_ADDR] = r_addr;
        o_burst.slots[sfb_pkg::SLOT_HDR_CTRL] = w_ctrl;
        o_burst.slots[sfb_pkg::SLOT_HDR_CHK]  = w_ctrl ^ r_addr;
        o_burst.slots[sfb_pkg::SLOT_DATA0]    = w_sd.b0;
        o_burst.slots[sfb_pkg::SLOT_DATA1]    = w_sd.b1;
        o_burst.slots[sfb_pkg::SLOT_CHK0]     = w_sc.b0;
        o_burst.slots[sfb_pkg::SLOT_CHK1]     = w_sc.b1;
        o_burst.slots[sfb_pkg::SLOT_CLOSE]    = r_flag;

        o_burst.mask = '0;
        o_burst.mask[sfb_pkg::SLOT_HDR_FLAG] = i_item.first_byte;
        o_burst.mask[sfb_pkg::SLOT_HDR_ADDR] = i_item.first_byte;
        o_burst.mask[sfb_pkg::SLOT_HDR_CTRL] = i_item.first_byte;
        o_burst.mask[sfb_pkg::SLOT_HDR_CHK]  = i_item.first_byte;
        o_burst.mask[sfb_pkg::SLOT_DATA0]    = w_active;
        o_burst.mask[sfb_pkg::SLOT_DATA1]    = w_active & w_sd.dbl;
        o_burst.mask[sfb_pkg::SLOT_CHK0]     = w_active & i_item.last_byte;
        o_burst.mask[sfb_pkg::SLOT_CHK1]     = w_active & i_item.last_byte & w_sc.dbl;
        o_burst.mask[sfb_pkg::SLOT_CLOSE]    = w_active & i_item.last_byte;
    end

    always_comb begin
        n_flag  = r_flag;
        n_addr  = r_addr;
        n_check = r_check;
        n_open  = r_open;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfb_pkg::CFG_FLAG: n_flag = i_cfg_wdata;
                sfb_pkg::CFG_ADDR: n_addr = i_cfg_wdata;
                default: ;
            endcase
        end
        if (i_accept && w_active) begin
            n_check = i_item.last_byte ? '0 : w_chk_new;
            n_open  = ~i_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= sfb_pkg::FLAG_RESET;
            r_addr  <= sfb_pkg::ADDR_RESET;
            r_check <= '0;
            r_open  <= 1'b0;
        end else begin
            r_flag  <= n_flag;
            r_addr  <= n_addr;
            r_check <= n_check;
            r_open  <= n_open;
        end
    end

endmodule

// File: design/sfb_emitter.sv
// Burst buffer and output register: drains one result byte per cycle while the output is not stalled.
// Depends on sfb_pkg.
module sfb_emitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  sfb_pkg::t_burst     i_burst,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output sfb_pkg::t_out_item  o_out,
    output sfb_pkg::t_emit_stat o_stat
);

    logic [sfb_pkg::NUM_SLOTS-1:0]                     r_mask, n_mask;
    logic [sfb_pkg::NUM_SLOTS-1:0][sfb_pkg::DATA_W-1:0] r_slots;
    logic                                              r_out_valid, n_out_valid;
    sfb_pkg::t_out_item                                r_out;

    logic [sfb_pkg::NUM_SLOTS-1:0] w_low;
    logic [sfb_pkg::NUM_SLOTS-1:0] w_rest;
    logic                          w_pop;
    logic [sfb_pkg::DATA_W-1:0]    w_byte;

    always_comb begin
        w_low  = r_mask & (-r_mask);   // lowest pending slot
        w_rest = r_mask & ~w_low;
        w_pop  = (r_mask != '0) && (!r_out_valid || !i_out_stall);
        w_byte = '0;
        for (int k = 0; k < sfb_pkg::NUM_SLOTS; k++) begin
            w_byte = w_byte | (r_slots[k] & {sfb_pkg::DATA_W{w_low[k]}});
        end
        // free for a new item once the last pending byte leaves this cycle
        o_stat.in_stall = (r_mask != '0) && !(w_pop && (w_rest == '0));
        o_stat.pending  = r_mask;

        n_mask = r_mask;
        if (i_accept) begin
            n_mask = i_burst.mask;
        end else if (w_pop) begin
            n_mask = w_rest;
        end
        n_out_valid = r_out_valid;
        if (w_pop) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_slots <= i_burst.slots;
        end
        if (w_pop) begin
            r_out.tx_byte   <= w_byte;
            r_out.run_last  <= (w_rest == '0);
            r_out.frame_end <= w_low[sfb_pkg::SLOT_CLOSE];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: design/stuffed_frame_builder_top.sv
// Channel    | valid       | stall       | payload
// input      | i_in_valid  | o_in_stall  | i_in  (sfb_pkg::t_in_item)
// output     | o_out_valid | i_out_stall | o_out (sfb_pkg::t_out_item)
// config     | i_cfg_we    | -           | i_cfg_idx, i_cfg_wdata
//
// One item per cycle when it yields one byte and the output is not stalled;
// else input stalls while the single output register drains the burst (up to
// nine bytes). Result bytes pass the burst buffer, then the output register.
// Synchronous active-low reset restores flag 0x7E, address 0x03, no frame open.
// A stalled output holds its byte; input stalls only while burst bytes remain.
// Depends on sfb_pkg, sfb_builder, sfb_emitter and the assertion macro header.
`include "stuffed_frame_builder_top_assert.svh"

module stuffed_frame_builder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sfb_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sfb_pkg::t_out_item            o_out,
    input  logic                          i_cfg_we,
    input  logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sfb_pkg::DATA_W-1:0]    i_cfg_wdata
);

    sfb_pkg::t_burst     w_burst;
    sfb_pkg::t_emit_stat w_stat;
    logic                w_accept;

    assign w_accept   = i_in_valid && !w_stat.in_stall;
    assign o_in_stall = w_stat.in_stall;

    sfb_builder u_builder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_item      (i_in),
        .o_burst     (w_burst)
    );

    sfb_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_burst     (w_burst),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_stat      (w_stat)
    );

    // closing flag is always the final byte of its item
    `SFB_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n,
        o_out_valid && o_out.frame_end, o_out.run_last, "closing flag without run_last")
    // more bytes of the same item keep the output occupied
    `SFB_ASSERT_NXT(a_burst_continues, i_clk, i_rst_n,
        o_out_valid && !o_out.run_last, o_out_valid, "output went idle inside a burst")
    // a frame start loads header plus at least one payload byte
    `SFB_ASSERT_NXT(a_header_loaded, i_clk, i_rst_n,
        w_accept && i_in.first_byte, $countones(w_stat.pending) >= 5,
        "frame start burst too short")

endmodule

// File: sim/tb_stuffed_frame_builder_top.sv
// Testbench for stuffed_frame_builder_top: header, byte stuffing, check byte and closing flag.
// Uses sfb_pkg for item types and register indexes. Table literals or a framer model check
// every output byte. Stimulus is a directed table, then random frames under several idle mixes.
`timescale 1ns / 100ps

module tb_stuffed_frame_builder_top;

    localparam logic [7:0] ESCAPE          = 8'h7D;
    localparam logic [7:0] ESCAPED_FLAG    = 8'h5E;
    localparam logic [7:0] ESCAPED_ESCAPE  = 8'h5D;
    localparam logic [7:0] CTRL_SEQ_SET    = 8'h40;
    localparam logic [7:0] CTRL_SEQ_CLEAR  = 8'h00;
    localparam logic [7:0] FLAG_AT_RESET   = 8'h7E;
    localparam logic [7:0] ADDR_AT_RESET   = 8'h03;
    localparam logic [sfb_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [sfb_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

    localparam int NO_LIT        = -1;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 26;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    // literal bytes are right aligned: first expected byte is lit[n_lit-1]
    typedef struct packed {
        t_row_kind                     kind;
        logic [sfb_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [7:0]                    reg_val;
        sfb_pkg::t_in_item             item;
        int                            n_lit;
        logic [8:0][7:0]               lit;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    sfb_pkg::t_in_item             i_in = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    sfb_pkg::t_out_item            o_out;
    logic                          i_cfg_we = 1'b0;
    logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [7:0]                    i_cfg_wdata = '0;

    // framer model state
    logic [7:0] model_flag   = FLAG_AT_RESET;
    logic [7:0] model_addr   = ADDR_AT_RESET;
    logic [7:0] run_xor      = '0;
    logic       frame_active = 1'b0;

    sfb_pkg::t_out_item tx_expected[$];
    sfb_pkg::t_out_item frame_bytes[$];
    t_dir_row           dir_rows[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_cnt   = 0;
    int cycle_cnt      = 0;

    stuffed_frame_builder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("stuffed_frame_builder_top test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    function automatic void push_frame_byte(input logic [7:0] b, input logic is_close);
        sfb_pkg::t_out_item r;
        r.tx_byte   = b;
        r.run_last  = 1'b0;
        r.frame_end = is_close;
        frame_bytes.push_back(r);
    endfunction

    function automatic void push_escaped(input logic [7:0] b);
        // flag compare wins even when the flag equals the escape byte
        if (b == model_flag) begin
            push_frame_byte(ESCAPE, 1'b0);
            push_frame_byte(ESCAPED_FLAG, 1'b0);
        end else if (b == ESCAPE) begin
            push_frame_byte(ESCAPE, 1'b0);
            push_frame_byte(ESCAPED_ESCAPE, 1'b0);
        end else begin
            push_frame_byte(b, 1'b0);
        end
    endfunction

    // fills frame_bytes with the output caused by one accepted item
    function automatic int framed_bytes_for(input sfb_pkg::t_in_item it);
        logic [7:0]         ctrl;
        sfb_pkg::t_out_item r;
        frame_bytes.delete();
        if (it.first_byte) begin
            ctrl = it.seq_bit ? CTRL_SEQ_SET : CTRL_SEQ_CLEAR;
            push_frame_byte(model_flag, 1'b0);
            push_frame_byte(model_addr, 1'b0);
            push_frame_byte(ctrl, 1'b0);
            push_frame_byte(ctrl ^ model_addr, 1'b0);
            run_xor      = '0;
            frame_active = 1'b1;
        end else if (!frame_active) begin
            return 0;
        end
        push_escaped(it.data_byte);
        run_xor = run_xor ^ it.data_byte;
        if (it.last_byte) begin
            push_escaped(run_xor);
            push_frame_byte(model_flag, 1'b1);
            run_xor      = '0;
            frame_active = 1'b0;
        end
        r = frame_bytes[frame_bytes.size()-1];
        r.run_last = 1'b1;
        frame_bytes[frame_bytes.size()-1] = r;
        return frame_bytes.size();
    endfunction

    function automatic int queue_expected(input sfb_pkg::t_in_item it, input int n_lit,
                                          input logic [8:0][7:0] lit);
        int                 n;
        sfb_pkg::t_out_item r;
        n = framed_bytes_for(it);
        if (n_lit == NO_LIT) begin
            foreach (frame_bytes[k]) tx_expected.push_back(frame_bytes[k]);
        end else begin
            for (int k = 0; k < n_lit; k++) begin
                r.tx_byte   = lit[n_lit-1-k];
                r.run_last  = (k == n_lit - 1);
                r.frame_end = (k == n_lit - 1) && it.last_byte;
                tx_expected.push_back(r);
            end
        end
        return n;
    endfunction

    function automatic void add_item(input logic [7:0] d, input logic f, input logic l,
                                     input logic s, input int n_lit,
                                     input logic [8:0][7:0] lit);
        t_dir_row row;
        row = '0;
        row.kind                 = ROW_ITEM;
        row.item.data_byte       = d;
        row.item.first_byte      = f;
        row.item.last_byte       = l;
        row.item.seq_bit         = s;
        row.n_lit                = n_lit;
        row.lit                  = lit;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [sfb_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [7:0] val);
        t_dir_row row;
        row = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(99);
        if (r < 20) return model_flag;
        if (r < 32) return ESCAPE;
        return 8'($urandom_range(255));
    endfunction

    // mostly well-formed frames; strays, lone ends and restarts as noise
    function automatic sfb_pkg::t_in_item next_random_item();
        sfb_pkg::t_in_item it;
        it.seq_bit   = 1'($urandom_range(1));
        it.data_byte = pick_data();
        it.last_byte = ($urandom_range(99) < 30);
        if (frame_active) begin
            it.first_byte = ($urandom_range(99) < 5);
        end else begin
            it.first_byte = ($urandom_range(99) < 90);
        end
        // steer the check byte into one of the escape cases
        if (frame_active && it.last_byte && !it.first_byte && $urandom_range(99) < 30) begin
            it.data_byte = run_xor ^ ($urandom_range(1) ? model_flag : ESCAPE);
        end
        return it;
    endfunction

    // entered and left at a falling edge; valid stays high after the accept
    task automatic offer_item(input sfb_pkg::t_in_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_block_idle();
        i_in_valid <= 1'b0;
        while (tx_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // leaves the write enable high; caller drops it after the last write
    task automatic write_reg(input logic [sfb_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == sfb_pkg::CFG_FLAG) model_flag = val;
        else if (idx == sfb_pkg::CFG_ADDR) model_addr = val;
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input sfb_pkg::t_out_item want,
                                   input sfb_pkg::t_out_item got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: %s: expected byte %h run_last %b frame_end %b, got %h %b %b",
                     $time, what, want.tx_byte, want.run_last, want.frame_end,
                     got.tx_byte, got.run_last, got.frame_end);
        end
    endtask

    always @(posedge i_clk) begin
        sfb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tx_expected.size() == 0) begin
                report_mismatch("unexpected output byte", '0, o_out);
            end else begin
                want = tx_expected.pop_front();
                if (o_out.tx_byte !== want.tx_byte || o_out.run_last !== want.run_last ||
                    o_out.frame_end !== want.frame_end) begin
                    report_mismatch("output byte mismatch", want, o_out);
                end
            end
        end
    end

    initial begin
        sfb_pkg::t_in_item it;
        logic              reg_phase;
        int                phase_items;
        logic [7:0]        phase_flag[4];
        logic [7:0]        phase_addr[4];
        int                phase_src[4];
        int                phase_sink[4];

        phase_flag = '{8'($urandom_range(255)), 8'h00, 8'hFF, 8'h7D};
        phase_addr = '{8'($urandom_range(255)), 8'hFF, 8'h00, 8'h7D};
        phase_src  = '{0, 72, 0, 26};
        phase_sink = '{0, 0, 72, 26};

        // defaults after reset: flag 7E, address 03
        add_item(8'h00, 1'b1, 1'b1, 1'b0, 7,
                 72'({8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h00, 8'h7E}));
        add_item(8'h55, 1'b0, 1'b0, 1'b0, 0, '0);
        add_item(8'hAA, 1'b0, 1'b1, 1'b1, 0, '0);
        add_item(8'h7E, 1'b1, 1'b0, 1'b1, 6,
                 72'({8'h7E, 8'h03, 8'h40, 8'h43, 8'h7D, 8'h5E}));
        add_item(8'h7D, 1'b0, 1'b0, 1'b0, 2, 72'({8'h7D, 8'h5D}));
        add_item(8'hFF, 1'b0, 1'b0, 1'b1, 1, 72'({8'hFF}));
        add_item(8'h01, 1'b0, 1'b1, 1'b0, 3, 72'({8'h01, 8'hFD, 8'h7E}));
        add_item(8'h7E, 1'b1, 1'b1, 1'b1, 9, {8'h7E, 8'h03, 8'h40, 8'h43, 8'h7D, 8'h5E,
                                              8'h7D, 8'h5E, 8'h7E});
        add_item(8'h12, 1'b1, 1'b0, 1'b0, NO_LIT, '0);
        add_item(8'h7D, 1'b1, 1'b0, 1'b1, NO_LIT, '0);   // restart abandons the open frame
        add_item(8'h03, 1'b0, 1'b1, 1'b0, NO_LIT, '0);   // check equals the flag and is escaped
        add_reg(sfb_pkg::CFG_FLAG, 8'h7D);
        add_reg(sfb_pkg::CFG_ADDR, 8'h7E);
        add_reg(REG_SPARE2, 8'h00);
        add_reg(REG_SPARE3, 8'h55);
        // header goes out raw; 7D is the flag now so it escapes to 7D 5E
        add_item(8'h7D, 1'b1, 1'b0, 1'b0, 6,
                 72'({8'h7D, 8'h7E, 8'h00, 8'h7E, 8'h7D, 8'h5E}));
        add_item(8'h7E, 1'b0, 1'b1, 1'b0, 3, 72'({8'h7E, 8'h03, 8'h7D}));
        add_reg(sfb_pkg::CFG_FLAG, 8'h00);
        add_reg(sfb_pkg::CFG_ADDR, 8'hFF);
        add_item(8'h00, 1'b1, 1'b1, 1'b1, 9, {8'h00, 8'hFF, 8'h40, 8'hBF, 8'h7D, 8'h5E,
                                              8'h7D, 8'h5E, 8'h00});
        add_reg(sfb_pkg::CFG_FLAG, 8'hFF);
        add_reg(sfb_pkg::CFG_ADDR, 8'h00);
        add_item(8'hFF, 1'b1, 1'b0, 1'b0, NO_LIT, '0);
        add_item(8'h80, 1'b0, 1'b1, 1'b1, NO_LIT, '0);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct   = 30;
        sink_stall_pct = 30;
        reg_phase      = 1'b0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG) begin
                if (!reg_phase) wait_block_idle();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
                reg_phase = 1'b1;
            end else begin
                if (reg_phase) i_cfg_we <= 1'b0;
                reg_phase = 1'b0;
                offer_item(dir_rows[r].item);
                void'(queue_expected(dir_rows[r].item, dir_rows[r].n_lit, dir_rows[r].lit));
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_block_idle();
            write_reg(sfb_pkg::CFG_FLAG, phase_flag[ph]);
            write_reg(sfb_pkg::CFG_ADDR, phase_addr[ph]);
            i_cfg_we       <= 1'b0;
            src_idle_pct   = phase_src[ph];
            sink_stall_pct = phase_sink[ph];
            phase_items    = 0;
            while (phase_items < PHASE_ITEMS) begin
                it = next_random_item();
                offer_item(it);
                if (queue_expected(it, NO_LIT, '0) > 0) phase_items++;
                // sender holds off until the output side has caught up
                if ($urandom_range(99) < 4) wait_block_idle();
            end
        end

        wait_block_idle();
        if (mismatch_cnt == 0 && tx_expected.size() == 0) begin
            $display("stuffed_frame_builder_top test passed");
        end else begin
            $display("stuffed_frame_builder_top test failed");
        end
        $finish;
    end

endmodule
